// ===== rtl/hlva_pkg.sv =====
// Shared constants for the Hough line vote accumulator.
package hlva_pkg;

	localparam int ACC_STRIDE  = 128;
	localparam int RHO_ROWS    = 512;
	localparam int COUNT_BITS  = 16;
	localparam int TABLE_DEPTH = 128;
	localparam int Q_SHIFT     = 16;

	localparam int COL_BITS    = $clog2(ACC_STRIDE);
	localparam int ROW_BITS    = $clog2(RHO_ROWS);
	localparam int CNT_AW      = ROW_BITS + COL_BITS;
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);
	localparam int THETA_LIMIT = (TABLE_DEPTH < ACC_STRIDE) ? TABLE_DEPTH : ACC_STRIDE;
	localparam int THETA_W     = $clog2(THETA_LIMIT) + 1;
	localparam int RHO_W       = 18;
	localparam int TRIG_W      = 22;
	localparam int COORD_W     = 12;
	localparam int PROD_W      = COORD_W + 1 + TRIG_W;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_VOTE  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// ===== rtl/hough_line_vote_accumulator.sv =====
// Hough line vote accumulator: sequencer, shared multiplier, trig tables and vote memory.
// After reset the block sweeps all RHO_ROWS*ACC_STRIDE = 65536 cells of the vote memory
// to zero, one cell a cycle, and stalls items meanwhile; configuration writes are taken
// at any time. A table load, or a clear of an in-range cell, writes on acceptance, then
// goes to FIN; a read of an in-range cell goes through CELL, then FIN. A vote walks the
// active theta bins one after another through the single multiplier and the read and
// write ports of the vote memory: each bin goes through TAB, MULC, MULS and ADD, then
// INC if its rho row lands in the array. One item is worked at a time; the result
// register lets the next item in while a result still waits to be taken.
module hough_line_vote_accumulator
	import hlva_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 mode,
	input  logic [6:0]                 theta_index,
	input  logic signed [TRIG_W-1:0]   cos_value,
	input  logic signed [TRIG_W-1:0]   sin_value,
	input  logic [COORD_W-1:0]         point_col,
	input  logic [COORD_W-1:0]         point_row,
	input  logic [8:0]                 rho_row,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [15:0]                cell_count,
	output logic [7:0]                 dropped_votes,
	output logic                       saturated,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [7:0]                 cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TAB  = 3'd1;
	localparam logic [2:0] ST_MULC = 3'd2;
	localparam logic [2:0] ST_MULS = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_INC  = 3'd5;
	localparam logic [2:0] ST_CELL = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]                state_q;
	logic                      clearing_q;
	logic [CNT_AW-1:0]         sweep_q;
	logic [7:0]                num_theta_q;
	logic [THETA_W-1:0]        t_q;
	logic [THETA_W-1:0]        n_theta;
	logic [THETA_W-1:0]        t_next;
	logic [COORD_W-1:0]        col_q;
	logic [COORD_W-1:0]        row_q;
	logic signed [TRIG_W-1:0]  cos_rd_q;
	logic signed [TRIG_W-1:0]  sin_rd_q;
	logic [31:0]               prod_q;
	logic [31:0]               acc_q;
	logic [31:0]               sum;
	logic signed [RHO_W-1:0]   r_s;
	logic                      r_ok;
	logic [CNT_AW-1:0]         addr_q;
	logic [7:0]                dropped_q;
	logic                      sat_q;
	count_t                    cell_q;
	logic                      result_valid_q;
	count_t                    result_cell_q;
	logic [7:0]                result_drop_q;
	logic                      result_sat_q;
	logic                      accept;
	logic                      result_take;
	logic                      fin_go;

	logic [COORD_W-1:0]        mul_a;
	logic signed [TRIG_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic signed [TRIG_W-1:0]  cos_mem [TABLE_DEPTH];
	logic signed [TRIG_W-1:0]  sin_mem [TABLE_DEPTH];
	count_t                    cnt_mem [2**CNT_AW];
	count_t                    cnt_rd_q;
	logic                      cnt_we;
	logic [CNT_AW-1:0]         cnt_waddr;
	count_t                    cnt_wdata;
	logic                      cnt_re;
	logic [CNT_AW-1:0]         cnt_raddr;
	count_t                    cnt_inc;
	logic                      cell_in_range;
	logic [CNT_AW-1:0]         cell_addr;

	assign item_stall    = clearing_q || (state_q != ST_IDLE);
	assign accept        = item_valid && !item_stall;
	assign cfg_ready     = 1'b1;
	assign result_take   = result_valid_q && !result_stall;
	assign fin_go        = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	assign result_valid  = result_valid_q;
	assign cell_count    = result_cell_q;
	assign dropped_votes = result_drop_q;
	assign saturated     = result_sat_q;

	assign n_theta = (num_theta_q > 8'(THETA_LIMIT)) ? THETA_W'(THETA_LIMIT)
		: THETA_W'(num_theta_q);
	assign t_next  = t_q + 1'b1;

	assign mul_a = (state_q == ST_MULC) ? col_q : row_q;
	assign mul_b = (state_q == ST_MULC) ? cos_rd_q : sin_rd_q;
	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	assign sum  = acc_q + prod_q;
	assign r_s  = RHO_W'(RHO_ROWS / 2) - {{(RHO_W - 16){sum[31]}}, sum[31:Q_SHIFT]};
	assign r_ok = !r_s[RHO_W-1] && (r_s < RHO_W'(RHO_ROWS));

	assign cell_in_range = (32'(rho_row) < RHO_ROWS) && (32'(theta_index) < ACC_STRIDE);
	assign cell_addr     = {ROW_BITS'(rho_row), COL_BITS'(theta_index)};
	assign cnt_inc       = (cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1;

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = addr_q;
		cnt_wdata = cnt_inc;
		if (clearing_q) begin
			cnt_we    = 1'b1;
			cnt_waddr = sweep_q;
			cnt_wdata = '0;
		end else if (accept && mode == MODE_CLEAR && cell_in_range) begin
			cnt_we    = 1'b1;
			cnt_waddr = cell_addr;
			cnt_wdata = '0;
		end else if (state_q == ST_INC) begin
			cnt_we = 1'b1;
		end
	end

	always_comb begin
		cnt_re    = 1'b0;
		cnt_raddr = cell_addr;
		if (accept && mode == MODE_READ) begin
			cnt_re = 1'b1;
		end else if (state_q == ST_ADD) begin
			cnt_re    = r_ok;
			cnt_raddr = {r_s[ROW_BITS-1:0], t_q[COL_BITS-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD) begin
			cos_mem[TAB_AW'(theta_index)] <= cos_value;
			sin_mem[TAB_AW'(theta_index)] <= sin_value;
		end
		if (state_q == ST_TAB) begin
			cos_rd_q <= cos_mem[t_q[TAB_AW-1:0]];
			sin_rd_q <= sin_mem[t_q[TAB_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= point_col;
			row_q <= point_row;
		end
		if (state_q == ST_MULC) begin
			prod_q <= mul_p[31:0];
		end
		if (state_q == ST_MULS) begin
			acc_q  <= prod_q;
			prod_q <= mul_p[31:0];
		end
		if (state_q == ST_ADD) begin
			addr_q <= {r_s[ROW_BITS-1:0], t_q[COL_BITS-1:0]};
		end
		if (fin_go) begin
			result_cell_q <= cell_q;
			result_drop_q <= dropped_q;
			result_sat_q  <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			sweep_q    <= '0;
		end else if (clearing_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == {CNT_AW{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_theta_q <= 8'(TABLE_DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			num_theta_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin_go) begin
			result_valid_q <= 1'b1;
		end else if (result_take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			t_q       <= '0;
			dropped_q <= '0;
			sat_q     <= 1'b0;
			cell_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						t_q       <= '0;
						dropped_q <= '0;
						sat_q     <= 1'b0;
						cell_q    <= '0;
						case (mode)
							MODE_VOTE: state_q <= (n_theta == '0) ? ST_FIN : ST_TAB;
							MODE_READ: state_q <= cell_in_range ? ST_CELL : ST_FIN;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_TAB:  state_q <= ST_MULC;
				ST_MULC: state_q <= ST_MULS;
				ST_MULS: state_q <= ST_ADD;
				ST_ADD: begin
					if (r_ok) begin
						state_q <= ST_INC;
					end else begin
						dropped_q <= dropped_q + 1'b1;
						t_q       <= t_next;
						state_q   <= (t_next == n_theta) ? ST_FIN : ST_TAB;
					end
				end
				ST_INC: begin
					if (cnt_inc == CNT_MAX) begin
						sat_q <= 1'b1;
					end
					t_q     <= t_next;
					state_q <= (t_next == n_theta) ? ST_FIN : ST_TAB;
				end
				ST_CELL: begin
					cell_q  <= cnt_rd_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_item_while_sweeping: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> item_stall)
		else $error("item accepted during clearing sweep");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAB) |-> (t_q < n_theta))
		else $error("theta bin beyond active count");

	a_inc_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INC) |-> ($past(state_q) == ST_ADD))
		else $error("cell update without rho calculation");

	a_drop_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (dropped_q <= 8'(THETA_LIMIT)))
		else $error("dropped count above theta limit");

	a_fin_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (result_valid_q && state_q == ST_IDLE))
		else $error("finished item did not reach result register");
`endif

endmodule
